>>> sv/fmr_pkg.sv
// Shared constants for the moving-average frame rate meter.
package fmr_pkg;

  localparam int unsigned TPS_W   = 20;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned RATE_W  = 28;
  localparam int unsigned FRAC_W  = 8;

  localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1000);
  localparam logic [RATE_W-1:0] RATE_MAX  = RATE_W'(256000000);

  // Transaction kinds carried on the input tuser bit.
  localparam logic MODE_RESTART = 1'b0;
  localparam logic MODE_FRAME   = 1'b1;

endpackage

>>> sv/fmr_front.sv
// Front end: accepts transactions and maintains the interval window, sum and fill count.
module fmr_front import fmr_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned CNT_W        = 5,
  parameter int unsigned SUM_W        = 36,
  parameter int unsigned ENT_W        = 42
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_mode_i,
  input  logic [STAMP_W-1:0] in_stamp_i,
  output logic               push_o,
  output logic [ENT_W-1:0]   push_data_o,
  input  logic               q_full_i
);

  localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  localparam logic [1:0] F_IDLE   = 2'd0;
  localparam logic [1:0] F_READ   = 2'd1;
  localparam logic [1:0] F_UPDATE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic               mode_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [STAMP_W-1:0] last_stamp_q, last_stamp_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [CNT_W-1:0]   filled_q, filled_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [STAMP_W-1:0] rd_data_q;
  logic [STAMP_W-1:0] ring_mem [WINDOW_DEPTH];

  logic               accept;
  logic               commit;
  logic               window_full;
  logic [STAMP_W-1:0] interval;
  logic [STAMP_W-1:0] old_entry;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]   filled_next;
  logic [SLOT_W-1:0]  slot_next;

  assign in_ready_o  = (state_q == F_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign commit      = (state_q == F_UPDATE) && !q_full_i;
  assign window_full = (filled_q == CNT_W'(WINDOW_DEPTH));

  // Entries beyond the fill count were never written since the last clear and read as zero.
  assign interval    = stamp_q - last_stamp_q;
  assign old_entry   = window_full ? rd_data_q : '0;
  assign sum_next    = sum_q - SUM_W'(old_entry) + SUM_W'(interval);
  assign filled_next = window_full ? filled_q : filled_q + CNT_W'(1);
  assign slot_next   = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);

  always_comb begin
    state_d      = state_q;
    last_stamp_d = last_stamp_q;
    slot_d       = slot_q;
    filled_d     = filled_q;
    sum_d        = sum_q;
    case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_READ;
      end
      F_READ: begin
        state_d = F_UPDATE;
      end
      F_UPDATE: begin
        if (commit) begin
          state_d      = F_IDLE;
          last_stamp_d = stamp_q;
          if (mode_q == MODE_FRAME) begin
            slot_d   = slot_next;
            filled_d = filled_next;
            sum_d    = sum_next;
          end else begin
            slot_d   = '0;
            filled_d = '0;
            sum_d    = '0;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign push_o      = commit;
  assign push_data_o = (mode_q == MODE_FRAME) ? {MODE_FRAME, filled_next, sum_next}
                                              : {MODE_RESTART, CNT_W'(0), SUM_W'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      last_stamp_q <= '0;
      slot_q       <= '0;
      filled_q     <= '0;
      sum_q        <= '0;
    end else begin
      state_q      <= state_d;
      last_stamp_q <= last_stamp_d;
      slot_q       <= slot_d;
      filled_q     <= filled_d;
      sum_q        <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= in_mode_i;
      stamp_q <= in_stamp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && (mode_q == MODE_FRAME)) ring_mem[slot_q] <= interval;
    if (state_q == F_READ) rd_data_q <= ring_mem[slot_q];
  end

  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count exceeds window depth");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (mode_q == MODE_RESTART) |=> (filled_q == '0) && (sum_q == '0) && (slot_q == '0))
    else $error("restart did not clear the window");

endmodule

>>> sv/fmr_queue.sv
// Two-entry queue that decouples the window update from the rate divider.
module fmr_queue #(
  parameter int unsigned WIDTH = 42
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule

>>> sv/fmr_back.sv
// Back end: multiplies, divides bit-serially and saturates to produce the rate.
module fmr_back import fmr_pkg::*; #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned SUM_W = 36,
  parameter int unsigned ENT_W = 42
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TPS_W-1:0]  tps_i,
  input  logic              q_valid_i,
  input  logic [ENT_W-1:0]  q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [RATE_W-1:0] out_rate_o,
  output logic              out_flag_o
);

  localparam int unsigned PROD_W = TPS_W + CNT_W;
  localparam int unsigned NUM_W  = PROD_W + FRAC_W;
  localparam int unsigned DCNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  filled_q, filled_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              flag_q, flag_d;
  logic              out_valid_q, out_valid_d;
  logic [RATE_W-1:0] out_rate_q, out_rate_d;
  logic              out_flag_q, out_flag_d;

  logic              ent_frame;
  logic [CNT_W-1:0]  ent_filled;
  logic [SUM_W-1:0]  ent_sum;
  logic [PROD_W-1:0] prod;
  logic [SUM_W:0]    shifted;
  logic              take;
  logic              load_out;
  logic [RATE_W-1:0] rate_sat;

  assign {ent_frame, ent_filled, ent_sum} = q_data_i;

  assign pop_o    = (state_q == B_IDLE) && q_valid_i;
  assign load_out = (state_q == B_DONE) && (!out_valid_q || out_ready_i);

  assign prod     = PROD_W'(tps_i) * PROD_W'(filled_q);
  assign shifted  = {rem_q, quo_q[NUM_W-1]};
  assign take     = (shifted >= {1'b0, sum_q});
  assign rate_sat = (quo_q > NUM_W'(RATE_MAX)) ? RATE_MAX : quo_q[RATE_W-1:0];

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    filled_d = filled_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    flag_d   = flag_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          sum_d    = ent_sum;
          filled_d = ent_filled;
          flag_d   = 1'b0;
          if (ent_frame != MODE_FRAME) begin
            quo_d   = '0;
            state_d = B_DONE;
          end else if (ent_sum == '0) begin
            quo_d   = NUM_W'(RATE_MAX);
            flag_d  = 1'b1;
            state_d = B_DONE;
          end else begin
            state_d = B_MUL;
          end
        end
      end
      B_MUL: begin
        quo_d   = {prod, FRAC_W'(0)};
        rem_d   = '0;
        cnt_d   = DCNT_W'(NUM_W);
        state_d = B_DIV;
      end
      B_DIV: begin
        rem_d = take ? SUM_W'(shifted - {1'b0, sum_q}) : shifted[SUM_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], take};
        cnt_d = cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) state_d = B_DONE;
      end
      B_DONE: begin
        if (load_out) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_rate_d  = out_rate_q;
    out_flag_d  = out_flag_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_rate_d  = rate_sat;
      out_flag_d  = flag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    filled_q   <= filled_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    flag_q     <= flag_d;
    out_rate_q <= out_rate_d;
    out_flag_q <= out_flag_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rate_o  = out_rate_q;
  assign out_flag_o  = out_flag_q;

  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_rate_q <= RATE_MAX))
    else $error("rate result above saturation limit");

  a_flag_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_flag_q |-> (out_rate_q == RATE_MAX))
    else $error("zero-interval flag without saturated rate");

endmodule

>>> sv/moving_average_frame_rate_meter.sv
// Top level of the moving-average frame rate meter.
//
// The input stream carries one transaction per event: tuser selects restart (0) or
// completed frame (1) and tdata carries the free-running 32-bit tick timestamp. Every
// input transaction yields exactly one output transaction: tdata holds the frame rate in
// frames per second with 8 fraction bits (zero after a restart) and tuser raises when the
// window sum is zero and the rate is pinned to its maximum.
// The front end takes a transaction, reads the overwritten ring entry from the interval
// memory and updates the running sum and fill count, in its idle, read and update states.
// A two-entry queue carries the window snapshot to the back end, which forms ticks_per_second
// times the fill count, then runs a restoring divider at one quotient bit per cycle. The
// quotient is NUM_W bits wide, where NUM_W is 28 plus the fill count width; the back end
// takes the next frame from the queue only after the last result has been loaded into
// the output register. Restarts and zero sums skip the divider.
// Reset clears the window, last timestamp and control state, and loads 1000 into
// ticks_per_second; the ring memory needs no clearing because entries beyond the fill
// count read as zero. When the receiver stalls, the result waits in the output register,
// the back end stops after its next result and the queue and front end fill behind it.
// The cfg port writes ticks_per_second and is meant to be used only while the block is idle.
module moving_average_frame_rate_meter import fmr_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration: ticks_per_second.
  input  logic               cfg_we_i,
  input  logic [TPS_W-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // [31:0] timestamp
  input  logic               s_axis_tuser,   // [0] mode
  // Output stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [27:0] rate_q8, [31:28] zero
  output logic               m_axis_tuser    // [0] zero_interval
);

  // Fill count holds 0..WINDOW_DEPTH; the sum holds WINDOW_DEPTH full-scale intervals.
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W = STAMP_W + $clog2(WINDOW_DEPTH);
  localparam int unsigned ENT_W = 1 + CNT_W + SUM_W;

  logic [TPS_W-1:0]  tps_q;
  logic              push;
  logic [ENT_W-1:0]  push_data;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  logic [ENT_W-1:0]  q_data;
  logic [RATE_W-1:0] rate;
  logic              zero_flag;

  // Rate scale, read directly by back end; user must change it only when idle, unenforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  fmr_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .CNT_W        (CNT_W),
    .SUM_W        (SUM_W),
    .ENT_W        (ENT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_stamp_i  (s_axis_tdata),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (q_full)
  );

  fmr_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  fmr_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W),
    .ENT_W (ENT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tps_i       (tps_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rate_o  (rate),
    .out_flag_o  (zero_flag)
  );

  assign m_axis_tdata = {(32 - RATE_W)'(0), rate};
  assign m_axis_tuser = zero_flag;

endmodule
